// ----- rtl/utf8c_pkg.sv -----
// Shared types and constants of the UTF-8 code point codec.
// No dependencies; every other file of the block refers to it by scoped names.
package utf8c_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CpInW  = 32;
  localparam int unsigned CpOutW = 21;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_INVALID = 1'b1
  } status_e;

  localparam logic [CpInW-1:0] SurrLo    = 32'h0000_D800;
  localparam logic [CpInW-1:0] SurrHi    = 32'h0000_DFFF;
  localparam logic [CpInW-1:0] CpMax     = 32'h0010_FFFF;
  localparam logic [CpInW-1:0] Min4Byte  = 32'h0001_0000;
  localparam logic [CpInW-1:0] Min3Byte  = 32'h0000_0800;
  localparam logic [CpInW-1:0] Min2Byte  = 32'h0000_0080;
  localparam logic [LenW-1:0]  MaxWindow = 3'd4;

endpackage

// ----- rtl/utf8c_in_if.sv -----
// Input channel of the codec: valid/ready handshake plus one request item.
// Depends on utf8c_pkg for field widths.
interface utf8c_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [utf8c_pkg::ByteW-1:0]          in_byte0;
  logic [utf8c_pkg::ByteW-1:0]          in_byte1;
  logic [utf8c_pkg::ByteW-1:0]          in_byte2;
  logic [utf8c_pkg::ByteW-1:0]          in_byte3;
  logic [utf8c_pkg::LenW-1:0]           bytes_available;
  logic signed [utf8c_pkg::CpInW-1:0]   code_point_in;

  modport source (output valid, opcode, in_byte0, in_byte1, in_byte2, in_byte3,
                  bytes_available, code_point_in, input ready);
  modport sink   (input valid, opcode, in_byte0, in_byte1, in_byte2, in_byte3,
                  bytes_available, code_point_in, output ready);
endinterface

// ----- rtl/utf8c_out_if.sv -----
// Output channel of the codec: valid/ready handshake plus one result item.
// Depends on utf8c_pkg for field widths.
interface utf8c_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [utf8c_pkg::LenW-1:0]     length;
  logic [utf8c_pkg::CpOutW-1:0]   code_point_out;
  logic [utf8c_pkg::ByteW-1:0]    out_byte0;
  logic [utf8c_pkg::ByteW-1:0]    out_byte1;
  logic [utf8c_pkg::ByteW-1:0]    out_byte2;
  logic [utf8c_pkg::ByteW-1:0]    out_byte3;

  modport source (output valid, status, length, code_point_out, out_byte0, out_byte1,
                  out_byte2, out_byte3, input ready);
  modport sink   (input valid, status, length, code_point_out, out_byte0, out_byte1,
                  out_byte2, out_byte3, output ready);
endinterface

// ----- rtl/utf8_codepoint_codec_core.sv -----
// UTF-8 codec core: decodes one character from a byte window or encodes one code point.
// Depends on utf8c_pkg, utf8c_in_if and utf8c_out_if.
//
// Each item passes a three-stage pipeline (classify, assemble, range check and
// output register). A result is offered on out_o from the output register once
// it has passed stages 1 and 2; one item is taken every cycle while in_i.ready is high.
// Each stage holds its item until the stage after it
// frees up, so downstream backpressure stalls the pipe without losing items;
// in_i.ready stays high while any stage has a bubble. Decode reports the bytes consumed
// and the code point; encode reports the bytes produced. An invalid request
// returns status invalid with every other field zero.
module utf8_codepoint_codec_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  utf8c_in_if.sink            in_i,
  utf8c_out_if.source         out_o
);

  typedef struct packed {
    logic                          op;
    logic                          bad;
    logic [utf8c_pkg::LenW-1:0]    len;
    logic [utf8c_pkg::ByteW-1:0]   b0;
    logic [utf8c_pkg::ByteW-1:0]   b1;
    logic [utf8c_pkg::ByteW-1:0]   b2;
    logic [utf8c_pkg::ByteW-1:0]   b3;
    logic [utf8c_pkg::CpOutW-1:0]  cp;
  } s1_t;

  typedef struct packed {
    logic                          op;
    logic                          bad;
    logic [utf8c_pkg::LenW-1:0]    len;
    logic [utf8c_pkg::CpOutW-1:0]  cp;
    logic [utf8c_pkg::ByteW-1:0]   e0;
    logic [utf8c_pkg::ByteW-1:0]   e1;
    logic [utf8c_pkg::ByteW-1:0]   e2;
    logic [utf8c_pkg::ByteW-1:0]   e3;
  } s2_t;

  typedef struct packed {
    logic                          status;
    logic [utf8c_pkg::LenW-1:0]    len;
    logic [utf8c_pkg::CpOutW-1:0]  cp;
    logic [utf8c_pkg::ByteW-1:0]   o0;
    logic [utf8c_pkg::ByteW-1:0]   o1;
    logic [utf8c_pkg::ByteW-1:0]   o2;
    logic [utf8c_pkg::ByteW-1:0]   o3;
  } s3_t;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // Stage 1: saturate the window, classify the lead byte, range-check encode input
  logic [utf8c_pkg::LenW-1:0]  avail;
  logic [utf8c_pkg::LenW-1:0]  dec_w;
  logic [utf8c_pkg::LenW-1:0]  enc_len;
  logic [utf8c_pkg::CpInW-1:0] raw;
  logic                        enc_bad;

  always_comb begin
    avail = (in_i.bytes_available > utf8c_pkg::MaxWindow) ? utf8c_pkg::MaxWindow
                                                          : in_i.bytes_available;
    priority if (!in_i.in_byte0[7])               dec_w = 3'd1;
    else if (in_i.in_byte0[7:5] == 3'b110)        dec_w = 3'd2;
    else if (in_i.in_byte0[7:4] == 4'b1110)       dec_w = 3'd3;
    else if (in_i.in_byte0[7:3] == 5'b11110)      dec_w = 3'd4;
    else                                          dec_w = 3'd0;

    raw     = in_i.code_point_in;
    enc_bad = raw[31] || (raw > utf8c_pkg::CpMax) ||
              ((raw >= utf8c_pkg::SurrLo) && (raw <= utf8c_pkg::SurrHi));
    priority if (raw < utf8c_pkg::Min2Byte)       enc_len = 3'd1;
    else if (raw < utf8c_pkg::Min3Byte)           enc_len = 3'd2;
    else if (raw < utf8c_pkg::Min4Byte)           enc_len = 3'd3;
    else                                          enc_len = 3'd4;

    s1_d.op = in_i.opcode;
    if (in_i.opcode == utf8c_pkg::OP_ENCODE) begin
      s1_d.bad = enc_bad;
      s1_d.len = enc_len;
    end else begin
      s1_d.bad = (avail == 3'd0) || (dec_w == 3'd0) || (dec_w > avail);
      s1_d.len = dec_w;
    end
    s1_d.b0 = in_i.in_byte0;
    s1_d.b1 = in_i.in_byte1;
    s1_d.b2 = in_i.in_byte2;
    s1_d.b3 = in_i.in_byte3;
    s1_d.cp = raw[utf8c_pkg::CpOutW-1:0];
  end

  // Stage 2: check continuation bytes and assemble the code point, or build bytes
  logic cont1, cont2, cont3;

  always_comb begin
    cont1 = (s1_q.b1[7:6] == 2'b10);
    cont2 = (s1_q.b2[7:6] == 2'b10);
    cont3 = (s1_q.b3[7:6] == 2'b10);
    s2_d.op  = s1_q.op;
    s2_d.len = s1_q.len;
    s2_d.cp  = '0;
    s2_d.e0  = '0;
    s2_d.e1  = '0;
    s2_d.e2  = '0;
    s2_d.e3  = '0;
    if (s1_q.op == utf8c_pkg::OP_ENCODE) begin
      s2_d.bad = s1_q.bad;
      unique case (s1_q.len)
        3'd1: s2_d.e0 = {1'b0, s1_q.cp[6:0]};
        3'd2: begin
          s2_d.e0 = {3'b110, s1_q.cp[10:6]};
          s2_d.e1 = {2'b10, s1_q.cp[5:0]};
        end
        3'd3: begin
          s2_d.e0 = {4'b1110, s1_q.cp[15:12]};
          s2_d.e1 = {2'b10, s1_q.cp[11:6]};
          s2_d.e2 = {2'b10, s1_q.cp[5:0]};
        end
        default: begin
          s2_d.e0 = {5'b11110, s1_q.cp[20:18]};
          s2_d.e1 = {2'b10, s1_q.cp[17:12]};
          s2_d.e2 = {2'b10, s1_q.cp[11:6]};
          s2_d.e3 = {2'b10, s1_q.cp[5:0]};
        end
      endcase
    end else begin
      s2_d.bad = s1_q.bad || ((s1_q.len >= 3'd2) && !cont1) ||
                 ((s1_q.len >= 3'd3) && !cont2) || ((s1_q.len == 3'd4) && !cont3);
      unique case (s1_q.len)
        3'd1:    s2_d.cp = {13'd0, s1_q.b0};
        3'd2:    s2_d.cp = {10'd0, s1_q.b0[4:0], s1_q.b1[5:0]};
        3'd3:    s2_d.cp = {5'd0, s1_q.b0[3:0], s1_q.b1[5:0], s1_q.b2[5:0]};
        3'd4:    s2_d.cp = {s1_q.b0[2:0], s1_q.b1[5:0], s1_q.b2[5:0], s1_q.b3[5:0]};
        default: s2_d.cp = '0;
      endcase
    end
  end

  // Stage 3: reject overlong, surrogate and out-of-range decodes; format result
  logic [utf8c_pkg::CpInW-1:0] cpw;
  logic                        range_bad;
  logic                        bad3;

  always_comb begin
    cpw = {{(utf8c_pkg::CpInW-utf8c_pkg::CpOutW){1'b0}}, s2_q.cp};
    unique case (s2_q.len)
      3'd2:    range_bad = (cpw < utf8c_pkg::Min2Byte);
      3'd3:    range_bad = (cpw < utf8c_pkg::Min3Byte) ||
                           ((cpw >= utf8c_pkg::SurrLo) && (cpw <= utf8c_pkg::SurrHi));
      3'd4:    range_bad = (cpw < utf8c_pkg::Min4Byte) || (cpw > utf8c_pkg::CpMax);
      default: range_bad = 1'b0;
    endcase
    bad3 = s2_q.bad || ((s2_q.op == utf8c_pkg::OP_DECODE) && range_bad);

    s3_d = '0;
    if (bad3) begin
      s3_d.status = utf8c_pkg::ST_INVALID;
    end else begin
      s3_d.status = utf8c_pkg::ST_OK;
      s3_d.len    = s2_q.len;
      if (s2_q.op == utf8c_pkg::OP_ENCODE) begin
        s3_d.o0 = s2_q.e0;
        s3_d.o1 = s2_q.e1;
        s3_d.o2 = s2_q.e2;
        s3_d.o3 = s2_q.e3;
      end else begin
        s3_d.cp = s2_q.cp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) s1_q <= s1_d;
    if (en2 && v1_q)       s2_q <= s2_d;
    if (en3 && v2_q)       s3_q <= s3_d;
  end

  assign out_o.valid          = v3_q;
  assign out_o.status         = s3_q.status;
  assign out_o.length         = s3_q.len;
  assign out_o.code_point_out = s3_q.cp;
  assign out_o.out_byte0      = s3_q.o0;
  assign out_o.out_byte1      = s3_q.o1;
  assign out_o.out_byte2      = s3_q.o2;
  assign out_o.out_byte3      = s3_q.o3;

  // A filled middle stage that can move on must land in the output register
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> v3_q)
    else $error("stage 2 item dropped on its way to the output register");

  // Invalid results carry nothing else
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == utf8c_pkg::ST_INVALID) |->
      (out_o.length == 3'd0 && out_o.code_point_out == '0 && out_o.out_byte0 == '0 &&
       out_o.out_byte1 == '0 && out_o.out_byte2 == '0 && out_o.out_byte3 == '0))
    else $error("invalid result with nonzero fields");

  // Good results use one to four bytes and never exceed the code space
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == utf8c_pkg::ST_OK) |->
      (out_o.length >= 3'd1 && out_o.length <= 3'd4 &&
       out_o.code_point_out <= utf8c_pkg::CpMax[utf8c_pkg::CpOutW-1:0]))
    else $error("good result with bad length or code point");

  // A result holding a decoded code point carries no encoded bytes in out_byte0 and out_byte1
  a_decode_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.code_point_out != '0) |->
      (out_o.out_byte0 == '0 && out_o.out_byte1 == '0))
    else $error("decode result with encoded bytes");

endmodule
